// ----- src/mmd_pkg.sv -----
// Shared types and constants for the mirrored memory map decoder.
// No dependencies.
`default_nettype none

package mmd_pkg;

  typedef enum logic [2:0] {
    OP_RD_B = 3'd0,
    OP_RD_H = 3'd1,
    OP_RD_W = 3'd2,
    OP_WR_B = 3'd3,
    OP_WR_H = 3'd4,
    OP_WR_W = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    REG_RAM  = 3'd0,
    REG_PAR  = 3'd1,
    REG_SCR  = 3'd2,
    REG_IO   = 3'd3,
    REG_BIOS = 3'd4,
    REG_NONE = 3'd5
  } region_e;

  localparam int unsigned OffW = 21;

  localparam logic [31:0] CacheCtrlAddr = 32'hfffe_0130;
  localparam logic [31:0] CcClrA        = 32'h0000_0800;
  localparam logic [31:0] CcClrB        = 32'h0000_0804;
  localparam logic [31:0] CcSetA        = 32'h0000_0000;
  localparam logic [31:0] CcSetB        = 32'h0001_e988;
  localparam logic [31:0] ScrEnd        = 32'h1f80_1000;
  localparam logic [15:0] PagePar       = 16'h1f00;
  localparam logic [15:0] PageScr       = 16'h1f80;
  localparam logic [12:0] WithinBios    = 13'h1fc0;
  localparam logic [12:0] WithinRamEnd  = 13'h0080;
  localparam int unsigned RamMirrorPages = 128;

  typedef struct packed {
    region_e           region;
    logic [OffW-1:0]   offset;
    logic              invalidate;
    logic [31:0]       inv_addr;
    logic              wen_set;
    logic              wen_clr;
  } dec_res_t;

endpackage

`default_nettype wire

// ----- src/mmd_decode.sv -----
// Combinational address decode: region, offset, invalidate and cache-control command.
// Depends on mmd_pkg.
`default_nettype none

module mmd_decode #(
  parameter int unsigned RAM_PAGES  = 32,
  parameter int unsigned BIOS_PAGES = 8
) (
  input  wire logic [2:0]      op_i,
  input  wire logic [31:0]     addr_i,
  input  wire logic [31:0]     data_i,
  input  wire logic            wen_i,
  output mmd_pkg::dec_res_t    res_o
);

  logic [4:0] ram_mod [mmd_pkg::RamMirrorPages];

  for (genvar g = 0; g < mmd_pkg::RamMirrorPages; g++) begin : g_mod
    localparam int unsigned Mod = g % RAM_PAGES;
    assign ram_mod[g] = 5'(Mod);
  end

  logic [15:0] page;
  logic [15:0] low;
  logic [2:0]  seg;
  logic [12:0] pg_idx;
  logic [12:0] bios_diff;
  logic        in_seg;
  logic        is_write;

  always_comb begin
    page      = addr_i[31:16];
    low       = addr_i[15:0];
    seg       = page[15:13];
    pg_idx    = page[12:0];
    bios_diff = pg_idx - mmd_pkg::WithinBios;
    in_seg    = (seg == 3'b000) || (seg == 3'b100) || (seg == 3'b101);
    is_write  = (op_i == mmd_pkg::OP_WR_B) || (op_i == mmd_pkg::OP_WR_H) ||
                (op_i == mmd_pkg::OP_WR_W);

    res_o = '0;
    res_o.region = mmd_pkg::REG_NONE;

    if (page == mmd_pkg::PageScr) begin
      res_o.offset = {5'd0, low};
      res_o.region = (addr_i < mmd_pkg::ScrEnd) ? mmd_pkg::REG_SCR : mmd_pkg::REG_IO;
    end else if (page == mmd_pkg::PagePar) begin
      res_o.offset = {5'd0, low};
      res_o.region = mmd_pkg::REG_PAR;
    end else if (in_seg && (pg_idx < mmd_pkg::WithinRamEnd)) begin
      if (!is_write || wen_i) begin
        res_o.offset = {ram_mod[pg_idx[6:0]], low};
        res_o.region = mmd_pkg::REG_RAM;
      end
    end else if (in_seg && !is_write && (pg_idx >= mmd_pkg::WithinBios) &&
                 (bios_diff < 13'(BIOS_PAGES))) begin
      res_o.offset = {bios_diff[4:0], low};
      res_o.region = mmd_pkg::REG_BIOS;
    end

    if (is_write) begin
      if ((res_o.region == mmd_pkg::REG_RAM) || (res_o.region == mmd_pkg::REG_PAR)) begin
        res_o.invalidate = 1'b1;
        if (op_i == mmd_pkg::OP_WR_B) begin
          res_o.inv_addr = {addr_i[31:2], 2'b00};
        end else if (op_i == mmd_pkg::OP_WR_H) begin
          res_o.inv_addr = {addr_i[31:1], 1'b0};
        end else begin
          res_o.inv_addr = addr_i;
        end
      end else if ((res_o.region == mmd_pkg::REG_NONE) && (op_i == mmd_pkg::OP_WR_W)) begin
        if (addr_i == mmd_pkg::CacheCtrlAddr) begin
          res_o.wen_clr = (data_i == mmd_pkg::CcClrA) || (data_i == mmd_pkg::CcClrB);
          res_o.wen_set = (data_i == mmd_pkg::CcSetA) || (data_i == mmd_pkg::CcSetB);
        end else if (!wen_i) begin
          res_o.invalidate = 1'b1;
          res_o.inv_addr   = addr_i;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/mmd_wen_reg.sv -----
// RAM write-enable flag, updated by cache-control word writes.
// Depends on nothing but the clock and reset.
`default_nettype none

module mmd_wen_reg (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic upd_i,
  input  wire logic set_i,
  input  wire logic clr_i,
  output wire logic wen_o
);

  logic wen_q;
  logic wen_d;

  always_comb begin
    wen_d = wen_q;
    if (upd_i && clr_i) begin
      wen_d = 1'b0;
    end else if (upd_i && set_i) begin
      wen_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wen_q <= 1'b1;
    end else begin
      wen_q <= wen_d;
    end
  end

  assign wen_o = wen_q;

endmodule

`default_nettype wire

// ----- src/mirrored_memory_map_decoder.sv -----
// Top level of the mirrored memory map decoder: input register, decode, result register.
// Depends on mmd_pkg, mmd_decode and mmd_wen_reg.
`default_nettype none

// One access word is taken per clock while in_stall_o is low: the access is
// captured in an input register, decoded by one short combinational stage
// against the RAM write-enable flag, and held in a result register until taken.
// Throughput is one word per cycle while the output is not stalled. A
// cache-control write changes the flag as its result is registered, so the very
// next access already decodes under the new setting.
module mirrored_memory_map_decoder #(
  parameter int unsigned RAM_PAGES  = 32,
  parameter int unsigned BIOS_PAGES = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output wire logic                     in_stall_o,
  input  wire logic [2:0]               opcode_i,
  input  wire logic [31:0]              address_i,
  input  wire logic [31:0]              write_data_i,
  output wire logic                     out_valid_o,
  input  wire logic                     out_stall_i,
  output wire logic [2:0]               region_o,
  output wire logic [mmd_pkg::OffW-1:0] offset_o,
  output wire logic                     invalidate_o,
  output wire logic [31:0]              invalidate_address_o
);

  logic                     s0_valid_q;
  logic [2:0]               s0_op_q;
  logic [31:0]              s0_addr_q;
  logic [31:0]              s0_data_q;
  logic                     out_valid_q;
  logic [2:0]               region_q;
  logic [mmd_pkg::OffW-1:0] offset_q;
  logic                     inv_q;
  logic [31:0]              inv_addr_q;

  logic                     out_free;
  logic                     s0_adv;
  logic                     in_take;
  logic                     wen;
  mmd_pkg::dec_res_t        dec;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s0_adv   = s0_valid_q && out_free;
  assign in_take  = in_valid_i && !in_stall_o;

  assign in_stall_o = s0_valid_q && !out_free;

  mmd_decode #(
    .RAM_PAGES  (RAM_PAGES),
    .BIOS_PAGES (BIOS_PAGES)
  ) u_decode (
    .op_i   (s0_op_q),
    .addr_i (s0_addr_q),
    .data_i (s0_data_q),
    .wen_i  (wen),
    .res_o  (dec)
  );

  mmd_wen_reg u_wen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (s0_adv),
    .set_i  (dec.wen_set),
    .clr_i  (dec.wen_clr),
    .wen_o  (wen)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s0_valid_q <= 1'b1;
      end else if (s0_adv) begin
        s0_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= s0_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s0_op_q   <= opcode_i;
      s0_addr_q <= address_i;
      s0_data_q <= write_data_i;
    end
    if (s0_adv) begin
      region_q   <= dec.region;
      offset_q   <= dec.offset;
      inv_q      <= dec.invalidate;
      inv_addr_q <= dec.inv_addr;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign region_o             = region_q;
  assign offset_o             = offset_q;
  assign invalidate_o         = inv_q;
  assign invalidate_address_o = inv_addr_q;

  a_inv_region : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && inv_q) |-> ((region_q == mmd_pkg::REG_RAM) ||
                                (region_q == mmd_pkg::REG_PAR) ||
                                (region_q == mmd_pkg::REG_NONE)))
    else $error("invalidate with scratchpad, io or bios region");

  a_inv_addr_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !inv_q) |-> (inv_addr_q == 32'd0))
    else $error("invalidate address nonzero without invalidate");

  a_none_offset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (region_q == mmd_pkg::REG_NONE)) |-> (offset_q == '0))
    else $error("unmapped word with nonzero offset");

  a_wen_fall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(wen) |-> $past(s0_adv && dec.wen_clr))
    else $error("write-enable cleared without cache-control word");

endmodule

`default_nettype wire
